[rtl/mmc_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmc_pkg
// Shared types, codes and defaults for the max-min matrix composition block.
// ----------------------------------------------------------------------------
package mmc_pkg;

	localparam int MATRIX_SIZE_DEF  = 4;
	localparam int ELEMENT_BITS_DEF = 16;

	// width of the row and column fields on both channels
	localparam int IDX_BITS = 2;

	// operation codes on the command channel
	localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
	localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
	localparam logic [1:0] OP_COMPUTE     = 2'd2;

	// command kinds held in the queue
	localparam logic [1:0] CMD_LOAD_A  = 2'd0;
	localparam logic [1:0] CMD_LOAD_B  = 2'd1;
	localparam logic [1:0] CMD_COMPUTE = 2'd2;

	typedef struct packed {
		logic [1:0]          kind;
		logic [IDX_BITS-1:0] row;
		logic [IDX_BITS-1:0] col;
	} cmd_t;

endpackage : mmc_pkg
`default_nettype wire

[rtl/mmc_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmc_front
// Accepts command beats, drops ignored ones and queues the rest in a
// two-entry queue for the compute side.
// ----------------------------------------------------------------------------
module mmc_front
	import mmc_pkg::*;
#(
	parameter int MATRIX_SIZE  = MATRIX_SIZE_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cmd_valid,
	output logic                         cmd_ready,
	input  wire logic [1:0]              operation,
	input  wire logic [IDX_BITS-1:0]     row,
	input  wire logic [IDX_BITS-1:0]     col,
	input  wire logic [ELEMENT_BITS-1:0] value,
	output logic                         q_valid,
	output cmd_t                         q_cmd,
	output logic [ELEMENT_BITS-1:0]      q_value,
	input  wire logic                    q_pop
);

	cmd_t                    cls_cmd;
	logic                    cls_keep;
	logic                    in_range;
	logic                    push;
	cmd_t                    ent_cmd_q   [2];
	logic [ELEMENT_BITS-1:0] ent_value_q [2];
	logic                    wr_ptr_q;
	logic                    rd_ptr_q;
	logic [1:0]              count_q;

	assign in_range = (int'(row) < MATRIX_SIZE) && (int'(col) < MATRIX_SIZE);

	always_comb begin
		cls_cmd.row  = row;
		cls_cmd.col  = col;
		cls_cmd.kind = CMD_COMPUTE;
		cls_keep     = 1'b0;
		unique case (operation)
			OP_LOAD_FIRST: begin
				cls_cmd.kind = CMD_LOAD_A;
				cls_keep     = in_range;
			end
			OP_LOAD_SECOND: begin
				cls_cmd.kind = CMD_LOAD_B;
				cls_keep     = in_range;
			end
			OP_COMPUTE: begin
				cls_cmd.kind = CMD_COMPUTE;
				cls_keep     = 1'b1;
			end
			default: begin
				cls_keep = 1'b0;
			end
		endcase
	end

	assign cmd_ready = (count_q != 2'd2);
	assign push      = cmd_valid && cmd_ready && cls_keep;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			ent_cmd_q[wr_ptr_q]   <= cls_cmd;
			ent_value_q[wr_ptr_q] <= value;
		end
	end

	assign q_valid = (count_q != 2'd0);
	assign q_cmd   = ent_cmd_q[rd_ptr_q];
	assign q_value = ent_value_q[rd_ptr_q];

endmodule : mmc_front
`default_nettype wire

[rtl/mmc_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mmc_back
// Executes queued commands: writes matrix banks, and for a compute walks
// the product in row-major order through a read stage and a min/max stage.
// ----------------------------------------------------------------------------
module mmc_back
	import mmc_pkg::*;
#(
	parameter int MATRIX_SIZE  = MATRIX_SIZE_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    q_valid,
	input  wire cmd_t                    q_cmd,
	input  wire logic [ELEMENT_BITS-1:0] q_value,
	output logic                         q_pop,
	output logic                         res_valid,
	input  wire logic                    res_ready,
	output logic [IDX_BITS-1:0]          out_row,
	output logic [IDX_BITS-1:0]          out_col,
	output logic [ELEMENT_BITS-1:0]      result,
	output logic                         last
);

	localparam int AW = (MATRIX_SIZE > 1) ? $clog2(MATRIX_SIZE) : 1;
	localparam logic [AW-1:0] LAST_IDX = AW'(MATRIX_SIZE - 1);

	// bank k of a holds column k of the first matrix, indexed by row;
	// bank k of b holds row k of the second matrix, indexed by column
	logic [ELEMENT_BITS-1:0] mem_a [MATRIX_SIZE][MATRIX_SIZE];
	logic [ELEMENT_BITS-1:0] mem_b [MATRIX_SIZE][MATRIX_SIZE];

	logic                    busy_q;
	logic [AW-1:0]           r_q;
	logic [AW-1:0]           c_q;
	logic                    adv;
	logic                    issue;
	logic                    issue_last;
	logic                    we_a;
	logic                    we_b;

	logic                    valid_s1;
	logic [AW-1:0]           r_s1;
	logic [AW-1:0]           c_s1;
	logic                    last_s1;
	logic signed [ELEMENT_BITS-1:0] a_s1 [MATRIX_SIZE];
	logic signed [ELEMENT_BITS-1:0] b_s1 [MATRIX_SIZE];

	logic signed [ELEMENT_BITS-1:0] best;

	logic                    out_valid_q;
	logic [IDX_BITS-1:0]     out_row_q;
	logic [IDX_BITS-1:0]     out_col_q;
	logic [ELEMENT_BITS-1:0] result_q;
	logic                    last_q;

	assign adv        = !out_valid_q || res_ready;
	assign issue      = busy_q && adv;
	assign issue_last = (r_q == LAST_IDX) && (c_q == LAST_IDX);
	assign q_pop      = q_valid && !busy_q;
	assign we_a       = q_pop && (q_cmd.kind == CMD_LOAD_A);
	assign we_b       = q_pop && (q_cmd.kind == CMD_LOAD_B);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			r_q    <= '0;
			c_q    <= '0;
		end else begin
			if (q_pop && (q_cmd.kind == CMD_COMPUTE)) begin
				busy_q <= 1'b1;
				r_q    <= '0;
				c_q    <= '0;
			end else if (issue) begin
				if (c_q == LAST_IDX) begin
					c_q <= '0;
					r_q <= r_q + AW'(1);
				end else begin
					c_q <= c_q + AW'(1);
				end
				if (issue_last) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	// bank writes and registered reads
	always_ff @(posedge clk) begin
		for (int k = 0; k < MATRIX_SIZE; k++) begin
			if (we_a && (int'(q_cmd.col) == k)) begin
				mem_a[k][AW'(q_cmd.row)] <= q_value;
			end
			if (we_b && (int'(q_cmd.row) == k)) begin
				mem_b[k][AW'(q_cmd.col)] <= q_value;
			end
			if (adv) begin
				a_s1[k] <= mem_a[k][r_q];
				b_s1[k] <= mem_b[k][c_q];
			end
		end
		if (adv) begin
			r_s1    <= r_q;
			c_s1    <= c_q;
			last_s1 <= issue_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= issue;
		end
	end

	// max over k of min(a, b)
	always_comb begin
		logic signed [ELEMENT_BITS-1:0] m;
		best = (a_s1[0] < b_s1[0]) ? a_s1[0] : b_s1[0];
		for (int k = 1; k < MATRIX_SIZE; k++) begin
			m = (a_s1[k] < b_s1[k]) ? a_s1[k] : b_s1[k];
			if (m > best) begin
				best = m;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_row_q <= IDX_BITS'(r_s1);
			out_col_q <= IDX_BITS'(c_s1);
			result_q  <= best;
			last_q    <= last_s1;
		end
	end

	assign res_valid = out_valid_q;
	assign out_row   = out_row_q;
	assign out_col   = out_col_q;
	assign result    = result_q;
	assign last      = last_q;

endmodule : mmc_back
`default_nettype wire

[rtl/max_min_matrix_composition.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// max_min_matrix_composition
// Max-min product of two square matrices loaded element by element.
// ----------------------------------------------------------------------------
// Load beats write one element of either matrix; loads with an
// out-of-range index and unused operation codes are dropped at the
// input. A compute beat streams all MATRIX_SIZE*MATRIX_SIZE product
// elements in row-major order, one per cycle while res_ready is high,
// with last marked on the final one. Each element is read from
// MATRIX_SIZE column banks and MATRIX_SIZE row banks in parallel and
// reduced by a chain of min/max comparisons. A two-entry command queue
// lets the input side queue up to two beats while a product streams
// out. Entries must be written before a compute reads them.
module max_min_matrix_composition
	import mmc_pkg::*;
#(
	parameter int MATRIX_SIZE  = MATRIX_SIZE_DEF,
	parameter int ELEMENT_BITS = ELEMENT_BITS_DEF
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    cmd_valid,
	output logic                         cmd_ready,
	input  wire logic [1:0]              operation,
	input  wire logic [IDX_BITS-1:0]     row,
	input  wire logic [IDX_BITS-1:0]     col,
	input  wire logic [ELEMENT_BITS-1:0] value,
	output logic                         res_valid,
	input  wire logic                    res_ready,
	output logic [IDX_BITS-1:0]          out_row,
	output logic [IDX_BITS-1:0]          out_col,
	output logic [ELEMENT_BITS-1:0]      result,
	output logic                         last
);

	logic                    q_valid;
	cmd_t                    q_cmd;
	logic [ELEMENT_BITS-1:0] q_value;
	logic                    q_pop;

	mmc_front #(
		.MATRIX_SIZE  (MATRIX_SIZE),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.operation (operation),
		.row       (row),
		.col       (col),
		.value     (value),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_value   (q_value),
		.q_pop     (q_pop)
	);

	mmc_back #(
		.MATRIX_SIZE  (MATRIX_SIZE),
		.ELEMENT_BITS (ELEMENT_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.q_value   (q_value),
		.q_pop     (q_pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.result    (result),
		.last      (last)
	);

endmodule : max_min_matrix_composition
`default_nettype wire

[bench/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the max-min matrix composition block.
// Loads both matrices, then mixes loads, dropped codes and compute commands
// under random idling on both channels. Every streamed product element is
// checked against a behavioral product held in the bench.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mmc_pkg::*;

	localparam int MS    = MATRIX_SIZE_DEF;
	localparam int EB    = ELEMENT_BITS_DEF;
	localparam int LIMIT = 200000;
	localparam int TAIL  = 20;
	localparam int RANDOM_BEATS = 375;

	localparam logic [1:0] OP_UNUSED = 2'd3;

	typedef struct packed {
		logic [1:0]          op;
		logic [IDX_BITS-1:0] r;
		logic [IDX_BITS-1:0] c;
		logic [EB-1:0]       v;
	} cmd_beat_t;

	typedef struct packed {
		logic [IDX_BITS-1:0] r;
		logic [IDX_BITS-1:0] c;
		logic [EB-1:0]       v;
		logic                lst;
	} product_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cmd_valid = 1'b0;
	logic [1:0]          operation = '0;
	logic [IDX_BITS-1:0] row       = '0;
	logic [IDX_BITS-1:0] col       = '0;
	logic [EB-1:0]       value     = '0;
	logic                res_ready = 1'b0;
	logic                cmd_ready;
	logic                res_valid;
	logic [IDX_BITS-1:0] out_row;
	logic [IDX_BITS-1:0] out_col;
	logic [EB-1:0]       result;
	logic                last;

	// product state mirrored in the bench
	logic signed [EB-1:0] mat_a [MS][MS];
	logic signed [EB-1:0] mat_b [MS][MS];

	cmd_beat_t pending_beats[$];
	product_t  product_q[$];
	cmd_beat_t cur_beat;

	int accepted_cnt = 0;
	int checked_cnt  = 0;
	int total_beats  = 1 << 20;
	int err_cnt      = 0;
	int cycle_cnt    = 0;
	int cmd_gap      = 0;
	int res_gap      = 0;

	logic [EB-1:0] corner_vals [16] = '{
		16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h5555, 16'haaaa, 16'h8001,
		16'h7ffe, 16'h0002, 16'hfffe, 16'h00ff, 16'hff00, 16'h0100, 16'hc000, 16'h3fff
	};

	// no idling once most of the stimulus is through
	wire calm = (accepted_cnt * 100 >= total_beats * 85);

	max_min_matrix_composition u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.operation (operation),
		.row       (row),
		.col       (col),
		.value     (value),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_row   (out_row),
		.out_col   (out_col),
		.result    (result),
		.last      (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	task automatic add_beat(input logic [1:0] op, input int r, input int c,
			input logic [EB-1:0] v);
		cmd_beat_t b;
		b.op = op;
		b.r  = IDX_BITS'(r);
		b.c  = IDX_BITS'(c);
		b.v  = v;
		pending_beats.push_back(b);
	endtask

	// update the mirrored matrices, or queue the whole max-min product
	task automatic record_beat(input cmd_beat_t b);
		product_t             p;
		logic signed [EB-1:0] best;
		logic signed [EB-1:0] m;
		int                   n;
		case (b.op)
			OP_LOAD_FIRST: begin
				if (b.r < MS && b.c < MS)
					mat_a[b.r][b.c] = b.v;
			end
			OP_LOAD_SECOND: begin
				if (b.r < MS && b.c < MS)
					mat_b[b.r][b.c] = b.v;
			end
			OP_COMPUTE: begin
				n = 0;
				for (int r = 0; r < MS; r++) begin
					for (int c = 0; c < MS; c++) begin
						best = (mat_a[r][0] < mat_b[0][c]) ? mat_a[r][0] : mat_b[0][c];
						for (int k = 1; k < MS; k++) begin
							m = (mat_a[r][k] < mat_b[k][c]) ? mat_a[r][k] : mat_b[k][c];
							if (m > best)
								best = m;
						end
						p.r   = IDX_BITS'(r);
						p.c   = IDX_BITS'(c);
						p.v   = best;
						p.lst = (n == MS * MS - 1);
						product_q.push_back(p);
						n++;
					end
				end
			end
			default: ;
		endcase
	endtask

	// command driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			operation <= '0;
			row       <= '0;
			col       <= '0;
			value     <= '0;
			cmd_gap = 0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				record_beat(cur_beat);
				accepted_cnt++;
			end
			if (!cmd_valid || cmd_ready) begin
				if (cmd_gap > 0) begin
					cmd_gap--;
					cmd_valid <= 1'b0;
				end else if (pending_beats.size() == 0) begin
					cmd_valid <= 1'b0;
				end else if (!calm && ((accepted_cnt / 50) % 3 != 1)
						&& $urandom_range(0, 5) == 0) begin
					cmd_gap = $urandom_range(0, 12);
					cmd_valid <= 1'b0;
				end else begin
					cur_beat = pending_beats.pop_front();
					cmd_valid <= 1'b1;
					operation <= cur_beat.op;
					row       <= cur_beat.r;
					col       <= cur_beat.c;
					value     <= cur_beat.v;
				end
			end
		end
	end

	// product monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		product_t exp_p;
		if (!arst_n) begin
			res_ready <= 1'b0;
			res_gap = 0;
		end else begin
			if (res_valid && res_ready) begin
				checked_cnt++;
				if (product_q.size() == 0) begin
					err_cnt++;
					if (err_cnt <= 10)
						$display("unexpected product beat (%0d,%0d) = %0d last %0b",
							out_row, out_col, $signed(result), last);
				end else begin
					exp_p = product_q.pop_front();
					if (exp_p.r !== out_row || exp_p.c !== out_col || exp_p.v !== result
							|| exp_p.lst !== last) begin
						err_cnt++;
						if (err_cnt <= 10)
							$display("exp (%0d,%0d)=%0d l%0b got (%0d,%0d)=%0d l%0b",
								exp_p.r, exp_p.c, $signed(exp_p.v), exp_p.lst,
								out_row, out_col, $signed(result), last);
					end
				end
			end
			if (res_gap > 0) begin
				res_gap--;
				res_ready <= 1'b0;
			end else if (!calm && ((checked_cnt / 40) % 3 != 2) && $urandom_range(0, 5) == 0) begin
				res_gap = $urandom_range(0, 12);
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= LIMIT) begin
			$display("max_min_matrix_composition verification failed");
			$finish;
		end
	end

	initial begin
		int            n;
		int            sel;
		logic [1:0]    op;
		logic [EB-1:0] v;

		// every entry written before the first compute, from the corner values
		for (int i = 0; i < MS * MS; i++)
			add_beat(OP_LOAD_FIRST, i / MS, i % MS, corner_vals[i]);
		for (int i = 0; i < MS * MS; i++)
			add_beat(OP_LOAD_SECOND, i / MS, i % MS, corner_vals[15 - i] ^ 16'h0f0f);
		add_beat(OP_COMPUTE, 0, 0, '0);
		// unused code must leave the matrices alone
		add_beat(OP_UNUSED, 3, 3, 16'hffff);
		add_beat(OP_COMPUTE, 3, 3, 16'hffff);
		add_beat(OP_LOAD_FIRST, 1, 2, 16'h7fff);
		add_beat(OP_LOAD_SECOND, 2, 1, 16'h8000);
		add_beat(OP_UNUSED, 0, 0, 16'h0000);
		// back to back computes fill the command queue
		add_beat(OP_COMPUTE, 1, 2, 16'h1234);
		add_beat(OP_COMPUTE, 2, 1, 16'hedcb);

		n = 0;
		while (n < RANDOM_BEATS) begin
			sel = $urandom_range(0, 99);
			case ($urandom_range(0, 3))
				0:       v = corner_vals[$urandom_range(0, 15)];
				1:       v = EB'($urandom_range(0, 6) - 3);
				default: v = EB'($urandom);
			endcase
			if (sel < 4) begin
				add_beat(OP_UNUSED, $urandom_range(0, 3), $urandom_range(0, 3), v);
			end else begin
				if (sel < 12)
					op = OP_COMPUTE;
				else if (sel[0])
					op = OP_LOAD_SECOND;
				else
					op = OP_LOAD_FIRST;
				add_beat(op, $urandom_range(0, 3), $urandom_range(0, 3), v);
				n++;
			end
		end
		total_beats = pending_beats.size();

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (accepted_cnt != total_beats || product_q.size() != 0)
			@(negedge clk);
		repeat (TAIL) @(negedge clk);

		if (err_cnt == 0)
			$display("max_min_matrix_composition verification clean");
		else
			$display("max_min_matrix_composition verification failed");
		$finish;
	end

endmodule
